FILE: rtl/core/b94_pkg.sv
`default_nettype none

package b94_pkg;

    localparam int ByteW      = 8;
    localparam int WordW      = 32;
    localparam int HeldW      = 24;
    localparam int CharW      = 7;
    localparam int GroupBytes = 4;
    localparam int CountW     = $clog2(GroupBytes);
    localparam int GroupChars = 5;
    localparam int LeftW      = $clog2(GroupChars + 1);
    localparam int DigitBase  = 94;
    localparam int CharOffset = 32;
    localparam int DigitW     = 8;

    // reciprocal of the base, scaled by two to the RecipShift
    localparam int RecipShift = 37;
    localparam logic [WordW-1:0] RecipM = WordW'((64'd1 << RecipShift) / DigitBase);
    localparam int QuotW = WordW + WordW - RecipShift;

    localparam logic [CountW-1:0] LastByte = CountW'(GroupBytes - 1);

    typedef struct packed {
        logic [WordW-1:0] word;
        logic             fin;
    } group_t;

endpackage

`default_nettype wire

FILE: rtl/core/b94_stream_if.sv
`default_nettype none

interface b94_in_if;
    import b94_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b94_out_if;
    import b94_pkg::*;

    logic             valid;
    logic             ready;
    logic [CharW-1:0] out_char;
    logic             final_char;

    modport source (output valid, output out_char, output final_char, input ready);
    modport sink (input valid, input out_char, input final_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/b94_group_packer.sv
`default_nettype none

module b94_group_packer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    b94_in_if.sink             bytes,
    output b94_pkg::group_t    grp,
    output logic               grp_valid,
    input  wire logic          grp_ready
);
    import b94_pkg::*;

    logic [HeldW-1:0]  held_reg;
    logic [HeldW-1:0]  held_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic              grp_valid_reg;
    logic              grp_valid_next;
    group_t            grp_reg;
    group_t            grp_next;
    logic              accept;
    logic              close;
    logic [WordW-1:0]  word;

    assign bytes.ready = !grp_valid_reg || grp_ready;
    assign accept      = bytes.valid && bytes.ready;
    assign close       = bytes.final_byte || (count_reg == LastByte);
    assign word        = {{(WordW-HeldW){1'b0}}, held_reg}
                       | (WordW'(bytes.data_byte) << {count_reg, 3'b000});

    always_comb
    begin
        held_next      = held_reg;
        count_next     = count_reg;
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg && !grp_ready;
        if (accept)
        begin
            if (close)
            begin
                held_next      = '0;
                count_next     = '0;
                grp_next.word  = word;
                grp_next.fin   = bytes.final_byte;
                grp_valid_next = 1'b1;
            end
            else
            begin
                held_next  = word[HeldW-1:0];
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            count_reg     <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            count_reg     <= count_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign grp       = grp_reg;
    assign grp_valid = grp_valid_reg;

`ifndef SYNTHESIS
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !close |=> count_reg == $past(count_reg) + 1'b1)
        else $error("byte count did not advance");
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && close |=> count_reg == '0 && held_reg == '0 && grp_valid_reg)
        else $error("closed group not handed on");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/b94_digit_unit.sv
`default_nettype none

module b94_digit_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire b94_pkg::group_t grp,
    input  wire logic          grp_valid,
    output logic               grp_ready,
    b94_out_if.source          chars
);
    import b94_pkg::*;

    logic [WordW-1:0]        work_reg;
    logic [WordW-1:0]        work_next;
    logic [LeftW-1:0]        left_reg;
    logic [LeftW-1:0]        left_next;
    logic                    fin_reg;
    logic                    fin_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [CharW-1:0]        out_char_reg;
    logic [CharW-1:0]        out_char_next;
    logic                    out_final_reg;
    logic                    out_final_next;
    logic                    adv;
    logic                    load;
    logic [2*WordW-1:0]      prod;
    logic [QuotW-1:0]        q_est;
    logic [WordW-1:0]        q_wide;
    logic [WordW-1:0]        back;
    logic [WordW-1:0]        rem_wide;
    logic [DigitW-1:0]       rem_est;
    logic                    rem_over;
    logic [DigitW-1:0]       digit;
    logic [WordW-1:0]        quot;

    // quotient estimate from the reciprocal, at most one short
    assign prod     = {{WordW{1'b0}}, work_reg} * {{WordW{1'b0}}, RecipM};
    assign q_est    = prod[2*WordW-1:RecipShift];
    assign q_wide   = WordW'(q_est);
    // times 94 as 64 + 32 - 2
    assign back     = (q_wide << 6) + (q_wide << 5) - (q_wide << 1);
    assign rem_wide = work_reg - back;
    assign rem_est  = rem_wide[DigitW-1:0];
    assign rem_over = rem_est >= DigitW'(DigitBase);
    assign digit    = rem_over ? rem_est - DigitW'(DigitBase) : rem_est;
    assign quot     = rem_over ? q_wide + 1'b1 : q_wide;

    assign adv       = (left_reg != '0) && (!out_valid_reg || chars.ready);
    assign grp_ready = (left_reg == '0) || ((left_reg == LeftW'(1)) && adv);
    assign load      = grp_valid && grp_ready;

    always_comb
    begin
        work_next      = work_reg;
        left_next      = left_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !chars.ready;
        out_char_next  = out_char_reg;
        out_final_next = out_final_reg;
        if (adv)
        begin
            work_next      = quot;
            left_next      = left_reg - 1'b1;
            out_valid_next = 1'b1;
            out_char_next  = CharW'(digit + DigitW'(CharOffset));
            out_final_next = fin_reg && (left_reg == LeftW'(1));
        end
        if (load)
        begin
            work_next = grp.word;
            left_next = LeftW'(GroupChars);
            fin_next  = grp.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        fin_reg       <= fin_next;
        out_char_reg  <= out_char_next;
        out_final_reg <= out_final_next;
    end

    assign chars.valid      = out_valid_reg;
    assign chars.out_char   = out_char_reg;
    assign chars.final_char = out_final_reg;

`ifndef SYNTHESIS
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= LeftW'(GroupChars))
        else $error("character count out of range");
    a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> left_reg == LeftW'(GroupChars))
        else $error("group load lost");
    a_adv_shows: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("character not presented");
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> digit < DigitW'(DigitBase))
        else $error("digit correction failed");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/base94_group_encoder_core.sv
`default_nettype none

// Base-94 group encoder. Raw bytes arrive on bytes, one transaction per byte, and are
// gathered four to a 32-bit word with the first byte lowest; a byte with final_byte
// set closes the group early, the missing high bytes reading as zero. Each closed
// group leaves on chars as five transactions, least significant base-94 digit first,
// each digit plus 32; final_char marks the fifth character of a group closed by a
// final byte. A byte can be taken every cycle unless stalled; a closed group goes to a
// single divide-by-94 unit (reciprocal multiply with one correction step) that makes one
// character per cycle unless chars stalls, so that unit sets the sustained rate at five
// characters per group. A closing byte passes the group, work and character registers
// before its first character appears. Both sides are registered, and the output register
// frees the byte side from stalls on chars until a second closed group is waiting.
module base94_group_encoder_core (
    input  wire logic clk,
    input  wire logic rst_n,
    b94_in_if.sink    bytes,
    b94_out_if.source chars
);
    import b94_pkg::*;

    group_t grp;
    logic   grp_valid;
    logic   grp_ready;

    b94_group_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .grp       (grp),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready)
    );

    b94_digit_unit u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .chars     (chars)
    );

`ifndef SYNTHESIS
    a_hold_then_take: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid && !grp_ready |=> grp_valid && $stable(grp))
        else $error("closed group dropped while waiting");
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.final_char |-> chars.out_char >= CharW'(CharOffset))
        else $error("final character out of range");
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid |-> chars.out_char <= CharW'(CharOffset + DigitBase - 1))
        else $error("character above printable range");
`endif

endmodule

`default_nettype wire

FILE: sim/base94_group_encoder_core_test.sv
`default_nettype none

module base94_group_encoder_core_test;
    import b94_pkg::*;

    localparam int DirRows     = 24;
    localparam int RandomBytes = 186;
    localparam int LongHold    = 80;
    localparam int QuietLimit  = 1000;
    localparam int TailCycles  = 10;

    localparam logic [5*CharW-1:0] NoChars  = '0;
    localparam logic [5*CharW-1:0] AllSpace = {5{7'd32}};
    localparam logic [5*CharW-1:0] AllOnes  = {7'd73, 7'd123, 7'd33, 7'd33, 7'd87};
    localparam logic [5*CharW-1:0] LoneFF   = {7'd99, 7'd34, 7'd32, 7'd32, 7'd32};

    typedef struct packed {
        logic [ByteW-1:0]     data;
        logic                 fin;
        logic                 typed;
        logic [5*CharW-1:0]   chars;
    } row_t;

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             fin;
    } char_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hold_req = 1'b0;

    b94_in_if  byte_ch ();
    b94_out_if char_ch ();

    base94_group_encoder_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .chars (char_ch)
    );

    always #2 clk = ~clk;

    row_t dir_rows [DirRows] = '{
        '{8'h00, 1'b1, 1'b1, AllSpace},
        '{8'hFF, 1'b0, 1'b0, NoChars},
        '{8'hFF, 1'b0, 1'b0, NoChars},
        '{8'hFF, 1'b0, 1'b0, NoChars},
        '{8'hFF, 1'b0, 1'b1, AllOnes},
        '{8'hFF, 1'b0, 1'b0, NoChars},
        '{8'hFF, 1'b0, 1'b0, NoChars},
        '{8'hFF, 1'b0, 1'b0, NoChars},
        '{8'hFF, 1'b1, 1'b1, AllOnes},
        '{8'hFF, 1'b1, 1'b1, LoneFF},
        '{8'h01, 1'b0, 1'b0, NoChars},
        '{8'h02, 1'b1, 1'b0, NoChars},
        '{8'h10, 1'b0, 1'b0, NoChars},
        '{8'h20, 1'b0, 1'b0, NoChars},
        '{8'h30, 1'b1, 1'b0, NoChars},
        '{8'h00, 1'b0, 1'b0, NoChars},
        '{8'h00, 1'b0, 1'b0, NoChars},
        '{8'h00, 1'b0, 1'b0, NoChars},
        '{8'h00, 1'b0, 1'b1, AllSpace},
        '{8'h80, 1'b0, 1'b0, NoChars},
        '{8'h7F, 1'b0, 1'b0, NoChars},
        '{8'h01, 1'b0, 1'b0, NoChars},
        '{8'hFE, 1'b0, 1'b0, NoChars},
        '{8'h55, 1'b1, 1'b0, NoChars}
    };

    char_item_t       pending_chars [$];
    char_item_t       want_item;
    logic [HeldW-1:0] open_bytes = '0;
    logic [CountW-1:0] open_count = '0;
    int               burst_left = 0;
    int               errors = 0;
    int               quiet_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    // gathers a byte into the open group and queues five characters when it closes
    task automatic take_byte(input logic [ByteW-1:0] b, input logic fin, input logic typed,
                             input logic [5*CharW-1:0] typed_chars);
        logic [WordW-1:0] word;
        char_item_t       item;
        word = {{(WordW-HeldW){1'b0}}, open_bytes} | (WordW'(b) << (ByteW * open_count));
        if (open_count != LastByte && !fin) begin
            open_bytes = word[HeldW-1:0];
            open_count = open_count + 1'b1;
        end
        else begin
            for (int k = 0; k < GroupChars; k++) begin
                item.ch  = CharW'(word % DigitBase + CharOffset);
                if (typed)
                    item.ch = typed_chars[5*CharW-1-CharW*k -: CharW];
                item.fin = fin && (k == GroupChars - 1);
                pending_chars.push_back(item);
                word = word / DigitBase;
            end
            open_bytes = '0;
            open_count = '0;
        end
    endtask

    task automatic offer_byte(input logic [ByteW-1:0] b, input logic fin, input logic typed,
                              input logic [5*CharW-1:0] typed_chars);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.final_byte <= fin;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        take_byte(b, fin, typed, typed_chars);
    endtask

    task automatic drain_chars();
        byte_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // receiver: changing stall pattern, plus one long hold-off on request
    initial
    begin
        int mode;
        int seg_left;
        seg_left = 0;
        mode = 0;
        char_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req      <= 1'b0;
                char_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            case (mode)
                0:       char_ch.ready <= 1'b1;
                1:       char_ch.ready <= 1'($urandom_range(0, 1));
                default: char_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else if (char_ch.valid && char_ch.ready)
            begin
                if (pending_chars.size() == 0)
                    report_mismatch("unexpected character", char_ch.out_char, -1);
                else
                begin
                    want_item = pending_chars.pop_front();
                    if (char_ch.out_char !== want_item.ch)
                        report_mismatch("out_char", char_ch.out_char, want_item.ch);
                    if (char_ch.final_char !== want_item.fin)
                        report_mismatch("final_char", char_ch.final_char, want_item.fin);
                end
            end
        end
    end

    initial
    begin
        int sent;
        int msg_len;
        int msg_idx;
        int r;
        logic [ByteW-1:0] b;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= '0;
        byte_ch.final_byte <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DirRows; i++)
            offer_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
                       dir_rows[i].chars);

        sent = 0;
        msg_idx = 0;
        while (sent < RandomBytes)
        begin
            if (msg_idx == 3)
            begin
                hold_req <= 1'b1;
                burst_left = 40;
            end
            if (msg_idx == 8)
                drain_chars();
            r = $urandom_range(0, 9);
            if (msg_idx == 3)
                msg_len = 30;
            else if (r < 4)
                msg_len = $urandom_range(1, 4);
            else if (r < 8)
                msg_len = $urandom_range(5, 16);
            else
                msg_len = $urandom_range(17, 40);
            for (int i = 0; i < msg_len; i++)
            begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    b = 8'h00;
                else if (r == 1)
                    b = 8'hFF;
                else
                    b = ByteW'($urandom);
                offer_byte(b, i == msg_len - 1, 1'b0, NoChars);
            end
            sent += msg_len;
            msg_idx++;
        end

        drain_chars();
        repeat (TailCycles) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/b94_pkg.sv
rtl/core/b94_stream_if.sv
rtl/core/b94_group_packer.sv
rtl/core/b94_digit_unit.sv
rtl/core/base94_group_encoder_core.sv
sim/base94_group_encoder_core_test.sv
